/* sv/htfc_pkg.sv */
`default_nettype none

package htfc_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned RAW_W  = 16;
    localparam int unsigned TEMP_W = 18;
    localparam int unsigned HUM_W  = 17;

    // CRC-8, polynomial 0x31, preset 0xFF, no output inversion
    localparam logic [BYTE_W-1:0] CRC_INIT = 8'hFF;
    localparam logic [BYTE_W-1:0] CRC_POLY = 8'h31;

    // frame positions
    localparam logic [2:0] POS_T_HI  = 3'd0;
    localparam logic [2:0] POS_T_LO  = 3'd1;
    localparam logic [2:0] POS_T_CRC = 3'd2;
    localparam logic [2:0] POS_H_HI  = 3'd3;
    localparam logic [2:0] POS_H_LO  = 3'd4;
    localparam logic [2:0] POS_H_CRC = 3'd5;

    // scaling: value = raw * scale / 1000, offset for temperature
    localparam int unsigned TEMP_PROD_W = 28;   // 65535 * 2672 < 2^28
    localparam int unsigned HUM_PROD_W  = 27;   // 65535 * 1526 < 2^27
    localparam logic [11:0] TEMP_SCALE  = 12'd2672;
    localparam logic [10:0] HUM_SCALE   = 11'd1526;
    localparam logic signed [TEMP_W:0] TEMP_OFFSET = -19'sd45000;

    // floor(p / 1000) = (p * ceil(2^38 / 1000)) >> 38, exact for p < 2^28
    localparam int unsigned RECIP_W     = 29;
    localparam int unsigned RECIP_SHIFT = 38;
    localparam logic [RECIP_W-1:0] DIV1000_RECIP = 29'd274877907;

    typedef struct packed {
        logic             good;
        logic [RAW_W-1:0] temp_raw;
        logic [RAW_W-1:0] hum_raw;
    } frame_t;

    function automatic logic [BYTE_W-1:0] crc8_update(
        input logic [BYTE_W-1:0] crc,
        input logic [BYTE_W-1:0] data
    );
        logic [BYTE_W-1:0] c;
        c = crc ^ data;
        for (int k = 0; k < BYTE_W; k++) begin
            if (c[BYTE_W-1]) begin
                c = {c[BYTE_W-2:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[BYTE_W-2:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

/* sv/htfc_frame.sv */
`default_nettype none

module htfc_frame
    import htfc_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              byte_accept,
    input  wire logic [BYTE_W-1:0] rx_byte,
    input  wire logic              frame_start,
    output logic                   frame_done,
    output frame_t                 frame
);

    logic [2:0]        pos_reg;
    logic [2:0]        pos_next;
    logic [BYTE_W-1:0] crc_reg;
    logic [BYTE_W-1:0] crc_next;
    logic [BYTE_W-1:0] high_reg;
    logic [BYTE_W-1:0] high_next;
    logic [BYTE_W-1:0] low_reg;
    logic [BYTE_W-1:0] low_next;
    logic [RAW_W-1:0]  temp_raw_reg;
    logic [RAW_W-1:0]  temp_raw_next;
    logic              temp_good_reg;
    logic              temp_good_next;

    logic [2:0]        pos;
    logic [BYTE_W-1:0] crc_seed;
    logic [BYTE_W-1:0] crc_upd;
    logic              crc_match;

    // out-of-range position codes behave as the start of a frame
    assign pos       = (frame_start || pos_reg > POS_H_CRC) ? POS_T_HI : pos_reg;
    assign crc_seed  = (pos == POS_T_HI || pos == POS_H_HI) ? CRC_INIT : crc_reg;
    assign crc_upd   = crc8_update(crc_seed, rx_byte);
    assign crc_match = (rx_byte == crc_reg);

    always_comb begin
        crc_next       = crc_reg;
        high_next      = high_reg;
        low_next       = low_reg;
        temp_raw_next  = temp_raw_reg;
        temp_good_next = temp_good_reg;
        pos_next       = pos_reg;
        if (byte_accept) begin
            pos_next = (pos >= POS_H_CRC) ? POS_T_HI : pos + 3'd1;
            case (pos) inside
                POS_T_HI, POS_H_HI: begin
                    crc_next  = crc_upd;
                    high_next = rx_byte;
                end
                POS_T_LO: begin
                    crc_next      = crc_upd;
                    low_next      = rx_byte;
                    temp_raw_next = {high_reg, rx_byte};
                end
                POS_H_LO: begin
                    crc_next = crc_upd;
                    low_next = rx_byte;
                end
                POS_T_CRC: begin
                    temp_good_next = crc_match;
                end
                default: begin
                end
            endcase
        end
    end

    assign frame_done     = byte_accept && (pos == POS_H_CRC);
    assign frame.good     = temp_good_reg && crc_match;
    assign frame.temp_raw = temp_raw_reg;
    assign frame.hum_raw  = {high_reg, low_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg       <= POS_T_HI;
            crc_reg       <= CRC_INIT;
            high_reg      <= '0;
            low_reg       <= '0;
            temp_raw_reg  <= '0;
            temp_good_reg <= 1'b0;
        end else begin
            pos_reg       <= pos_next;
            crc_reg       <= crc_next;
            high_reg      <= high_next;
            low_reg       <= low_next;
            temp_raw_reg  <= temp_raw_next;
            temp_good_reg <= temp_good_next;
        end
    end

endmodule

`default_nettype wire

/* sv/humidity_temp_frame_checker.sv */
// Channel   Direction  tdata (low bit up)                         tuser
// s_axis    in         rx_byte[7:0]                               frame_start
// m_axis    out        temp_millideg[17:0], hum_millipct[34:18],  status
//                      zero pad[39:35]
//
// One byte is taken every cycle while m_axis is not backed up. A result
// appears after the sixth byte of a frame, through the frame register, the
// scale-multiply register and the divide-by-1000 (reciprocal multiply) output register.
// Synchronous active-low reset clears the frame position, CRC and all valids.
// A stall on m_axis holds the pipeline; bubbles are squeezed out before
// s_axis_tready drops.
`default_nettype none

module humidity_temp_frame_checker
    import htfc_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // rx_byte
    input  wire logic        s_axis_tuser,   // frame_start
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,   // temp_millideg, hum_millipct, pad
    output logic             m_axis_tuser    // status
);

    logic   byte_accept;
    logic   frame_done;
    frame_t frame;

    logic   s1_valid_reg;
    logic   s1_valid_next;
    frame_t s1_frame_reg;

    logic                   s2_valid_reg;
    logic                   s2_valid_next;
    logic                   s2_good_reg;
    logic [TEMP_PROD_W-1:0] s2_temp_prod_reg;
    logic [TEMP_PROD_W-1:0] s2_temp_prod_next;
    logic [HUM_PROD_W-1:0]  s2_hum_prod_reg;
    logic [HUM_PROD_W-1:0]  s2_hum_prod_next;

    logic                   m_valid_reg;
    logic                   m_valid_next;
    logic [TEMP_W-1:0]      m_temp_reg;
    logic [TEMP_W-1:0]      m_temp_next;
    logic [HUM_W-1:0]       m_hum_reg;
    logic [HUM_W-1:0]       m_hum_next;
    logic                   m_status_reg;

    logic m_load;
    logic s2_load;

    logic [TEMP_PROD_W+RECIP_W-1:0] temp_div_prod;
    logic [HUM_PROD_W+RECIP_W-1:0]  hum_div_prod;
    logic [TEMP_W-1:0]              temp_q;
    logic [HUM_W-1:0]               hum_q;
    logic signed [TEMP_W:0]         temp_off;

    assign m_load        = s2_valid_reg && (!m_valid_reg || m_axis_tready);
    assign s2_load       = s1_valid_reg && (!s2_valid_reg || m_load);
    assign s_axis_tready = !s1_valid_reg || s2_load;
    assign byte_accept   = s_axis_tvalid && s_axis_tready;

    htfc_frame u_frame (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .byte_accept (byte_accept),
        .rx_byte     (s_axis_tdata),
        .frame_start (s_axis_tuser),
        .frame_done  (frame_done),
        .frame       (frame)
    );

    assign s1_valid_next = frame_done || (s1_valid_reg && !s2_load);
    assign s2_valid_next = s2_load || (s2_valid_reg && !m_load);
    assign m_valid_next  = m_load || (m_valid_reg && !m_axis_tready);

    assign s2_temp_prod_next = {{(TEMP_PROD_W-RAW_W){1'b0}}, s1_frame_reg.temp_raw}
                             * {{(TEMP_PROD_W-12){1'b0}}, TEMP_SCALE};
    assign s2_hum_prod_next  = {{(HUM_PROD_W-RAW_W){1'b0}}, s1_frame_reg.hum_raw}
                             * {{(HUM_PROD_W-11){1'b0}}, HUM_SCALE};

    assign temp_div_prod = {{RECIP_W{1'b0}}, s2_temp_prod_reg}
                         * {{TEMP_PROD_W{1'b0}}, DIV1000_RECIP};
    assign hum_div_prod  = {{RECIP_W{1'b0}}, s2_hum_prod_reg}
                         * {{HUM_PROD_W{1'b0}}, DIV1000_RECIP};
    assign temp_q   = temp_div_prod[RECIP_SHIFT+TEMP_W-1:RECIP_SHIFT];
    assign hum_q    = hum_div_prod[RECIP_SHIFT+HUM_W-1:RECIP_SHIFT];
    assign temp_off = $signed({1'b0, temp_q}) + TEMP_OFFSET;

    // values are forced to zero when either CRC failed
    assign m_temp_next = s2_good_reg ? temp_off[TEMP_W-1:0] : '0;
    assign m_hum_next  = s2_good_reg ? hum_q : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (frame_done) begin
            s1_frame_reg <= frame;
        end
        if (s2_load) begin
            s2_good_reg      <= s1_frame_reg.good;
            s2_temp_prod_reg <= s2_temp_prod_next;
            s2_hum_prod_reg  <= s2_hum_prod_next;
        end
        if (m_load) begin
            m_temp_reg   <= m_temp_next;
            m_hum_reg    <= m_hum_next;
            m_status_reg <= !s2_good_reg;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {5'b0, m_hum_reg, m_temp_reg};
    assign m_axis_tuser  = m_status_reg;

endmodule

`default_nettype wire
